/* hw/rtl/laps_pkg.sv */
// ----------------------------------------------------------------------------
// laps_pkg
// Shared types and codes for the LED action priority sequencer.
// ----------------------------------------------------------------------------
package laps_pkg;

    // Operation codes
    localparam logic [2:0] OP_SUBMIT = 3'd0;
    localparam logic [2:0] OP_OVERRIDE = 3'd1;
    localparam logic [2:0] OP_LAMP = 3'd2;
    localparam logic [2:0] OP_RESET_LOCAL = 3'd3;
    localparam logic [2:0] OP_TICK = 3'd4;

    // Effect codes
    localparam logic [2:0] FX_OFF = 3'd0;
    localparam logic [2:0] FX_ON = 3'd1;
    localparam logic [2:0] FX_INACTIVE = 3'd5;

    // Priority levels
    localparam logic [1:0] LVL_LAMP = 2'd0;
    localparam logic [1:0] LVL_OVERRIDE = 2'd1;
    localparam logic [1:0] LVL_LOCAL = 2'd2;

    // Appearance of one action
    typedef struct packed {
        logic [2:0]  effect;
        logic [7:0]  intensity;
        logic [15:0] period;
        logic [15:0] time_on;
    } t_look;

    // Commands from the sequencer to the queue
    typedef struct packed {
        logic push;
        logic pop;
        logic clear;
    } t_queue_cmd;

    // Queue status back to the sequencer
    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_stat;

endpackage

/* hw/rtl/laps_queue.sv */
// ----------------------------------------------------------------------------
// laps_queue
// Circular queue of local actions in a single-port-read memory.
// ----------------------------------------------------------------------------
module laps_queue #(
    parameter int QUEUE_DEPTH = 8,
    parameter int TIME_WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  laps_pkg::t_queue_cmd     i_cmd,
    input  laps_pkg::t_look          i_wr_look,
    input  logic [TIME_WIDTH-1:0]    i_wr_time,
    output laps_pkg::t_queue_stat    o_stat,
    output laps_pkg::t_look          o_rd_look,
    output logic [TIME_WIDTH-1:0]    o_rd_time
);
    import laps_pkg::*;

    localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;

    t_look               r_look_mem [QUEUE_DEPTH];
    logic [TIME_WIDTH-1:0] r_time_mem [QUEUE_DEPTH];
    logic [IDX_W-1:0]    r_head;
    logic [CNT_W-1:0]    r_count;
    logic [IDX_W-1:0]    w_tail;
    logic [IDX_W-1:0]    w_head_inc;
    logic [SUM_W-1:0]    w_sum;

    // Locate the tail slot, wrapping past the end
    always_comb begin
        w_sum = SUM_W'(r_head) + SUM_W'(r_count);
        if (w_sum >= SUM_W'(QUEUE_DEPTH)) begin
            w_sum = w_sum - SUM_W'(QUEUE_DEPTH);
        end
        w_tail = w_sum[IDX_W-1:0];
        if (r_head == IDX_W'(QUEUE_DEPTH - 1)) begin
            w_head_inc = '0;
        end else begin
            w_head_inc = r_head + 1'b1;
        end
    end

    assign o_stat.full = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_stat.empty = (r_count == '0);

    // Write at the tail, read at the head
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_look_mem[w_tail] <= i_wr_look;
            r_time_mem[w_tail] <= i_wr_time;
        end
        if (i_cmd.pop) begin
            o_rd_look <= r_look_mem[r_head];
            o_rd_time <= r_time_mem[r_head];
        end
    end

    // Track head and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_count <= '0;
        end else begin
            priority if (i_cmd.clear) begin
                r_head <= '0;
                r_count <= '0;
            end else if (i_cmd.push) begin
                r_count <= r_count + 1'b1;
            end else if (i_cmd.pop) begin
                r_head <= w_head_inc;
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

/* hw/rtl/led_action_priority_sequencer.sv */
// ----------------------------------------------------------------------------
// led_action_priority_sequencer
// Three-level LED action arbiter: lamp test, override, queued local actions.
// ----------------------------------------------------------------------------
// Each item is one command (submit, override, lamp test, reset local, tick)
// and yields one result with the winning effect, its level and the ticks
// left. Items run one at a time. An override, lamp test, reset local or
// unused op goes from ST_EXEC straight to ST_RESULT; a submit pushes in
// ST_EXEC and then takes queued actions while the local hold is spent,
// through ST_POP_CHECK and ST_POP_LOAD (a submit to a full queue goes
// straight to ST_RESULT); a tick steps ST_DEC_LAMP and ST_DEC_LOCAL first.
// The steps follow from the single decrement/zero unit shared by both
// counters and from the one read port of the queue memory, whose read data
// is registered. A stalled result waits in ST_RESULT. Submits to a full
// queue are flagged in dropped and change nothing.
module led_action_priority_sequencer #(
    parameter int QUEUE_DEPTH = 8,
    parameter int TIME_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_op,
    input  logic [2:0]  i_effect,
    input  logic [31:0] i_duration,
    input  logic [7:0]  i_intensity,
    input  logic [15:0] i_period,
    input  logic [15:0] i_time_on,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_out_effect,
    output logic [7:0]  o_out_intensity,
    output logic [15:0] o_out_period,
    output logic [15:0] o_out_time_on,
    output logic [1:0]  o_level,
    output logic [31:0] o_remaining,
    output logic        o_dropped
);
    import laps_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DEC_LAMP,
        ST_DEC_LOCAL,
        ST_POP_CHECK,
        ST_POP_LOAD,
        ST_RESULT
    } t_state;

    t_state                r_state;
    logic [2:0]            r_op;
    t_look                 r_in_look;
    logic [TIME_WIDTH-1:0] r_in_time;
    t_look                 r_local;
    logic [TIME_WIDTH-1:0] r_local_left;
    t_look                 r_override;
    logic [TIME_WIDTH-1:0] r_lamp_left;
    logic                  r_dropped;
    logic                  r_o_valid;

    t_look                 w_norm_look;
    t_queue_cmd            w_cmd;
    t_queue_stat           w_stat;
    t_look                 w_rd_look;
    logic [TIME_WIDTH-1:0] w_rd_time;
    logic [TIME_WIDTH-1:0] w_dec_arg;
    logic [TIME_WIDTH-1:0] w_dec_res;
    logic                  w_dec_zero;
    logic                  w_out_free;

    // Normalize the incoming appearance; effect codes above FX_INACTIVE count as inactive
    always_comb begin
        w_norm_look.effect = (i_effect > FX_INACTIVE) ? FX_INACTIVE : i_effect;
        w_norm_look.intensity = i_intensity;
        w_norm_look.period = i_period;
        w_norm_look.time_on = i_time_on;
    end

    // Shared decrement and zero-detect unit
    assign w_dec_arg = (r_state == ST_DEC_LAMP) ? r_lamp_left : r_local_left;
    assign w_dec_zero = (w_dec_arg == '0);
    assign w_dec_res = w_dec_zero ? w_dec_arg : (w_dec_arg - 1'b1);

    // Drive queue commands from the sequencer
    always_comb begin
        w_cmd.push = (r_state == ST_EXEC) && (r_op == OP_SUBMIT) && !w_stat.full;
        w_cmd.clear = (r_state == ST_EXEC) && (r_op == OP_RESET_LOCAL);
        w_cmd.pop = (r_state == ST_POP_CHECK) && w_dec_zero && !w_stat.empty;
    end

    laps_queue #(
        .QUEUE_DEPTH(QUEUE_DEPTH),
        .TIME_WIDTH (TIME_WIDTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .i_wr_look(r_in_look),
        .i_wr_time(r_in_time),
        .o_stat   (w_stat),
        .o_rd_look(w_rd_look),
        .o_rd_time(w_rd_time)
    );

    assign w_out_free = !r_o_valid || !i_stall;
    assign o_stall = (r_state != ST_IDLE);
    assign o_valid = r_o_valid;

    // Sequencer, action state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_o_valid <= 1'b0;
            r_local <= '{effect: FX_OFF, intensity: '0, period: '0, time_on: '0};
            r_local_left <= '0;
            r_override <= '{effect: FX_INACTIVE, intensity: '0, period: '0,
                            time_on: '0};
            r_lamp_left <= '0;
            r_dropped <= 1'b0;
        end else begin
            // Drop the taken result unless a new one replaces it this cycle
            if (r_o_valid && !i_stall && (r_state != ST_RESULT)) begin
                r_o_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_valid) begin
                        r_op <= i_op;
                        r_in_look <= w_norm_look;
                        r_in_time <= TIME_WIDTH'(i_duration);
                        r_dropped <= 1'b0;
                        r_state <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    r_state <= ST_RESULT;
                    unique case (r_op)
                        OP_SUBMIT: begin
                            if (w_stat.full) begin
                                r_dropped <= 1'b1;
                            end else begin
                                r_state <= ST_POP_CHECK;
                            end
                        end
                        OP_OVERRIDE: r_override <= r_in_look;
                        OP_LAMP: r_lamp_left <= r_in_time;
                        OP_RESET_LOCAL: r_local_left <= '0;
                        OP_TICK: r_state <= ST_DEC_LAMP;
                        default: ;
                    endcase
                end
                ST_DEC_LAMP: begin
                    r_lamp_left <= w_dec_res;
                    r_state <= ST_DEC_LOCAL;
                end
                ST_DEC_LOCAL: begin
                    r_local_left <= w_dec_res;
                    r_state <= ST_POP_CHECK;
                end
                ST_POP_CHECK: begin
                    // Take the head entry while the hold is spent
                    if (w_cmd.pop) begin
                        r_state <= ST_POP_LOAD;
                    end else begin
                        r_state <= ST_RESULT;
                    end
                end
                ST_POP_LOAD: begin
                    r_local <= w_rd_look;
                    r_local_left <= w_rd_time;
                    r_state <= ST_POP_CHECK;
                end
                ST_RESULT: begin
                    // Pick the winner and hand it out when the slot frees
                    if (w_out_free) begin
                        r_o_valid <= 1'b1;
                        o_dropped <= r_dropped;
                        priority if (r_lamp_left != '0) begin
                            o_out_effect <= FX_ON;
                            o_out_intensity <= '0;
                            o_out_period <= '0;
                            o_out_time_on <= '0;
                            o_level <= LVL_LAMP;
                            o_remaining <= 32'(r_lamp_left);
                        end else if (r_override.effect != FX_INACTIVE) begin
                            o_out_effect <= r_override.effect;
                            o_out_intensity <= r_override.intensity;
                            o_out_period <= r_override.period;
                            o_out_time_on <= r_override.time_on;
                            o_level <= LVL_OVERRIDE;
                            o_remaining <= '1;
                        end else begin
                            o_out_effect <= r_local.effect;
                            o_out_intensity <= r_local.intensity;
                            o_out_period <= r_local.period;
                            o_out_time_on <= r_local.time_on;
                            o_level <= LVL_LOCAL;
                            o_remaining <= 32'(r_local_left);
                        end
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule
